>>> design/bmcr_pkg.sv
// Shared types, constants and the status decision of the best-match collision resolver.
`default_nettype none

package bmcr_pkg;

   // Field widths fixed by the item formats.
   localparam int SCORE_W = 8;
   localparam int MIN_W   = SCORE_W + 1;
   localparam int IDX_W   = 10;
   localparam int MODE_W  = 2;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP        = 2'd2;

   // Collision rules.
   localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNIQUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GAP    = 2'd2;

   // Register reset values.
   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_UNIQUE;
   localparam logic [SCORE_W-1:0] LIMIT_RESET = 8'd1;
   localparam logic [SCORE_W-1:0] GAP_RESET   = 8'd2;

   // Running minimum before any score has been seen.
   localparam logic [MIN_W-1:0] MIN_RESET = '1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_COLLISION = 2'd1,
      STATUS_BEYOND    = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // Summary of a list as it stands after the current item.
   typedef struct packed {
      logic             overflow;
      logic             beyond;
      logic             within_many;
      logic             tie_one;
      logic             gap_hit;
      logic [IDX_W-1:0] position;
   } summary_type;

   // Picks the list status from the summary under the selected rule.
   function automatic status_type resolve(input summary_type sum,
                                          input logic [MODE_W-1:0] mode);
      status_type st;
      if (sum.overflow) begin
         st = STATUS_OVERFLOW;
      end else begin
         case (mode)
            MODE_COUNT: begin
               if (sum.within_many)  st = STATUS_COLLISION;
               else if (!sum.beyond) st = STATUS_FOUND;
               else                  st = STATUS_BEYOND;
            end
            MODE_GAP: begin
               if (sum.beyond)       st = STATUS_BEYOND;
               else if (sum.gap_hit) st = STATUS_COLLISION;
               else                  st = STATUS_FOUND;
            end
            default: begin
               // Unique minimum rule, also taken for the unused mode code.
               if (sum.beyond)       st = STATUS_BEYOND;
               else if (sum.tie_one) st = STATUS_FOUND;
               else                  st = STATUS_COLLISION;
            end
         endcase
      end
      return st;
   endfunction

endpackage

`default_nettype wire

>>> design/bmcr_if.sv
// Stream interfaces for score items and result items.
`default_nettype none

interface bmcr_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmcr_pkg::SCORE_W-1:0] score;
   logic                         last;

   modport source (output valid, output score, output last, input ready);
   modport sink   (input valid, input score, input last, output ready);
endinterface

interface bmcr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [bmcr_pkg::IDX_W-1:0] best_index;

   modport source (output valid, output status, output best_index, input ready);
   modport sink   (input valid, input status, input best_index, output ready);
endinterface

`default_nettype wire

>>> design/best_match_collision_resolver_top.sv
// Top level of the best-match collision resolver: item register, list state, result register.
`default_nettype none

// Scores of one read against a list of candidate barcodes enter one item per clock unless a
// last item stalls; the item flagged last closes the list and produces one result (status
// and best index), loaded into the result register as that item leaves the item register.
// Items that are not last produce nothing. Throughput is one item per cycle while no last
// item waits on a full result slot, set by the update of the running minimum, the counters
// and the 256-entry presence bitmap, whose window check is a row of parallel distance
// compares. A stalled result holds the last item in the item register and blocks further
// items. The user must write configuration through the csr_ port only while no list is in
// flight; the block does not enforce this. It takes effect from the next item.

module best_match_collision_resolver_top #(
   parameter int MAX_CANDIDATES = 1024,
   parameter int SCORE_LEVELS   = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bmcr_req_if.sink                            req_if,
   bmcr_rsp_if.source                          rsp_if,
   input  wire logic                           csr_wr_en,
   input  wire logic [bmcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bmcr_pkg::CSR_W-1:0]     csr_wr_data
);

   // Configuration registers.
   logic [bmcr_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [bmcr_pkg::SCORE_W-1:0] limit_ff, limit_in;
   logic [bmcr_pkg::SCORE_W-1:0] gap_ff, gap_in;

   // Item register.
   logic                         stage_vld_ff, stage_vld_in;
   logic [bmcr_pkg::SCORE_W-1:0] stage_score_ff, stage_score_in;
   logic                         stage_last_ff, stage_last_in;

   // Result register.
   logic                         rsp_vld_ff, rsp_vld_in;
   bmcr_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [bmcr_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;

   bmcr_pkg::summary_type        summary;
   bmcr_pkg::status_type         status;
   logic                         advance;
   logic                         accept;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      mode_in  = mode_ff;
      limit_in = limit_ff;
      gap_in   = gap_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bmcr_pkg::CSR_MODE:           mode_in  = csr_wr_data[bmcr_pkg::MODE_W-1:0];
            bmcr_pkg::CSR_MISMATCH_LIMIT: limit_in = csr_wr_data;
            bmcr_pkg::CSR_MIN_GAP:        gap_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   // The held item moves on unless it is a last item and the result slot is still full.
   assign advance      = stage_vld_ff &&
                         (!stage_last_ff || !rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !stage_vld_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      stage_vld_in   = stage_vld_ff;
      stage_score_in = stage_score_ff;
      stage_last_in  = stage_last_ff;
      if (accept) begin
         stage_vld_in   = 1'b1;
         stage_score_in = req_if.score;
         stage_last_in  = req_if.last;
      end else if (advance) begin
         stage_vld_in = 1'b0;
      end
   end

   bmcr_acc #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .SCORE_LEVELS   (SCORE_LEVELS)
   ) u_acc (
      .clock          (clock),
      .reset          (reset),
      .take           (advance),
      .score          (stage_score_ff),
      .last           (stage_last_ff),
      .mismatch_limit (limit_ff),
      .min_gap        (gap_ff),
      .summary        (summary)
   );

   assign status = bmcr_pkg::resolve(summary, mode_ff);

   // Result slot: loaded by a closing item, emptied when taken.
   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (advance && stage_last_ff) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = status;
         rsp_index_in  = (status == bmcr_pkg::STATUS_FOUND) ? summary.position : '0;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.best_index = rsp_index_ff;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bmcr_pkg::MODE_RESET;
         limit_ff     <= bmcr_pkg::LIMIT_RESET;
         gap_ff       <= bmcr_pkg::GAP_RESET;
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         limit_ff     <= limit_in;
         gap_ff       <= gap_in;
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stage_score_ff <= stage_score_in;
      stage_last_ff  <= stage_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
   end

   // A closing item that moves on always leaves a result behind.
   a_close_gives_result : assert property (@(posedge clock) disable iff (reset)
      (advance && stage_last_ff) |=> rsp_vld_ff)
      else $error("closing item produced no result");

   // The best index is only reported with a found status.
   a_index_only_found : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_status_ff != bmcr_pkg::STATUS_FOUND)) |-> (rsp_index_ff == '0))
      else $error("best index set without found status");

   // A held item that cannot move on is still held in the next cycle.
   a_stall_keeps_item : assert property (@(posedge clock) disable iff (reset)
      (stage_vld_ff && !advance) |=> (stage_vld_ff && $stable(stage_last_ff)))
      else $error("stalled item lost");

endmodule

`default_nettype wire

>>> design/bmcr_window.sv
// Presence bitmap of in-threshold scores and the minimum-gap window check.
`default_nettype none

module bmcr_window #(
   parameter int SCORE_LEVELS = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         mark_en,
   input  wire logic                         clear_en,
   input  wire logic [bmcr_pkg::SCORE_W-1:0] score,
   input  wire logic [bmcr_pkg::SCORE_W-1:0] min_gap,
   output      logic                         hit
);

   // Only values an 8-bit score can reach are kept.
   localparam int MAP_W = (SCORE_LEVELS < (1 << bmcr_pkg::SCORE_W)) ?
                          SCORE_LEVELS : (1 << bmcr_pkg::SCORE_W);

   logic [MAP_W-1:0] seen_ff;
   logic [MAP_W-1:0] seen_in;
   logic [MAP_W-1:0] near;
   logic             in_map;

   assign in_map = ({24'd0, score} < 32'(MAP_W));

   // One distance compare per bitmap entry, all in parallel.
   for (genvar i = 0; i < MAP_W; i++) begin : g_near
      logic [bmcr_pkg::SCORE_W-1:0] entry;
      logic [bmcr_pkg::SCORE_W-1:0] span;
      assign entry   = bmcr_pkg::SCORE_W'(i);
      assign span    = (entry >= score) ? (entry - score) : (score - entry);
      assign near[i] = seen_ff[i] && (span < min_gap);
   end

   assign hit = in_map && (|near);

   // A finished list clears the map; otherwise the new score is marked.
   always_comb begin
      seen_in = seen_ff;
      if (clear_en) begin
         seen_in = '0;
      end else if (mark_en && in_map) begin
         seen_in = seen_ff | (MAP_W'(1) << score);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

>>> design/bmcr_acc.sv
// Per-list running state: count, minimum, ties, in-threshold count and gap flag.
`default_nettype none

module bmcr_acc #(
   parameter int MAX_CANDIDATES = 1024,
   parameter int SCORE_LEVELS   = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         take,
   input  wire logic [bmcr_pkg::SCORE_W-1:0] score,
   input  wire logic                         last,
   input  wire logic [bmcr_pkg::SCORE_W-1:0] mismatch_limit,
   input  wire logic [bmcr_pkg::SCORE_W-1:0] min_gap,
   output      bmcr_pkg::summary_type        summary
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 2);
   localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(MAX_CANDIDATES);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_CANDIDATES + 1);

   logic [CNT_W-1:0]              count_ff, count_in;
   logic [bmcr_pkg::MIN_W-1:0]    min_ff, min_in;
   logic [bmcr_pkg::IDX_W-1:0]    pos_ff, pos_in;
   logic [1:0]                    tie_ff, tie_in;
   logic [1:0]                    within_ff, within_in;
   logic                          gap_ff, gap_in;

   logic [bmcr_pkg::MIN_W-1:0]    min_nx;
   logic [bmcr_pkg::IDX_W-1:0]    pos_nx;
   logic [1:0]                    tie_nx, within_nx;
   logic                          gap_nx;
   logic [CNT_W-1:0]              count_nx;
   logic                          in_cap;
   logic                          in_limit;
   logic                          win_hit;

   assign in_cap   = (count_ff < CNT_CAP);
   assign in_limit = (score <= mismatch_limit);

   bmcr_window #(
      .SCORE_LEVELS (SCORE_LEVELS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .mark_en  (take && in_cap && in_limit),
      .clear_en (take && last),
      .score    (score),
      .min_gap  (min_gap),
      .hit      (win_hit)
   );

   // State after this item; items beyond capacity only push the counter to overflow.
   always_comb begin
      min_nx    = min_ff;
      pos_nx    = pos_ff;
      tie_nx    = tie_ff;
      within_nx = within_ff;
      gap_nx    = gap_ff;
      count_nx  = CNT_OVER;
      if (in_cap) begin
         count_nx = count_ff + CNT_W'(1);
         if ({1'b0, score} < min_ff) begin
            min_nx = {1'b0, score};
            pos_nx = bmcr_pkg::IDX_W'(count_ff);
            tie_nx = 2'd1;
         end else if ({1'b0, score} == min_ff) begin
            if (tie_ff != 2'd2) tie_nx = tie_ff + 2'd1;
         end
         if (in_limit) begin
            if (within_ff != 2'd2) within_nx = within_ff + 2'd1;
            if (win_hit) gap_nx = 1'b1;
         end
      end
   end

   // The summary describes the list including the item now being taken.
   always_comb begin
      summary.overflow    = (count_nx > CNT_CAP);
      summary.beyond      = (min_nx > {1'b0, mismatch_limit});
      summary.within_many = (within_nx == 2'd2);
      summary.tie_one     = (tie_nx == 2'd1);
      summary.gap_hit     = gap_nx;
      summary.position    = pos_nx;
   end

   // The last item of a list returns everything to the empty-list values.
   always_comb begin
      count_in  = count_ff;
      min_in    = min_ff;
      pos_in    = pos_ff;
      tie_in    = tie_ff;
      within_in = within_ff;
      gap_in    = gap_ff;
      if (take) begin
         if (last) begin
            count_in  = '0;
            min_in    = bmcr_pkg::MIN_RESET;
            pos_in    = '0;
            tie_in    = '0;
            within_in = '0;
            gap_in    = 1'b0;
         end else begin
            count_in  = count_nx;
            min_in    = min_nx;
            pos_in    = pos_nx;
            tie_in    = tie_nx;
            within_in = within_nx;
            gap_in    = gap_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= bmcr_pkg::MIN_RESET;
         pos_ff    <= '0;
         tie_ff    <= '0;
         within_ff <= '0;
         gap_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         min_ff    <= min_in;
         pos_ff    <= pos_in;
         tie_ff    <= tie_in;
         within_ff <= within_in;
         gap_ff    <= gap_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the best-match collision resolver.

module tb_top;

   // Capacity and bitmap size of the block as instantiated.
   localparam int CAPACITY = 1024;
   localparam int LEVELS   = 256;

   // The unused mode code, which the block treats as the unique minimum rule.
   localparam logic [bmcr_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   // Length of the long result hold-off used to fill the block.
   localparam int HOLD_OFF_CYCLES = 300;

   // Expected outcome of one list.
   typedef struct {
      bmcr_pkg::status_type       status;
      logic [bmcr_pkg::IDX_W-1:0] index;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_wr_en   = 1'b0;
   logic [bmcr_pkg::CSR_IDX_W-1:0] csr_index   = bmcr_pkg::CSR_MODE;
   logic [bmcr_pkg::CSR_W-1:0]     csr_wr_data = '0;

   bmcr_req_if score_ch ();
   bmcr_rsp_if verdict_ch ();

   best_match_collision_resolver_top #(
      .MAX_CANDIDATES(CAPACITY),
      .SCORE_LEVELS  (LEVELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (score_ch),
      .rsp_if     (verdict_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Clock with a period of ten time units.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Copy of the register settings as last written.
   logic [bmcr_pkg::MODE_W-1:0]  cfg_mode  = bmcr_pkg::MODE_RESET;
   logic [bmcr_pkg::SCORE_W-1:0] cfg_limit = bmcr_pkg::LIMIT_RESET;
   logic [bmcr_pkg::SCORE_W-1:0] cfg_gap   = bmcr_pkg::GAP_RESET;

   // Running state of the list currently streaming in.
   int unsigned      list_len;
   int unsigned      low_score;
   int unsigned      low_pos;
   int unsigned      low_ties;
   int unsigned      in_limit_count;
   logic [LEVELS-1:0] seen_levels;
   bit               gap_seen;

   verdict_type awaited_verdicts[$];

   // Idling control and bookkeeping.
   int unsigned send_idle_max = 0;
   int unsigned recv_idle_max = 0;
   int unsigned recv_wait;
   int unsigned recv_hold;
   int unsigned hold_asked = 0;
   int unsigned hold_granted = 0;
   int unsigned error_count = 0;
   int unsigned items_accepted = 0;
   int unsigned settings_used = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned status_tally[4];

   // Mismatches are counted; only the first 40 are printed.
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic void clear_list();
      list_len       = 0;
      low_score      = 511;
      low_pos        = 0;
      low_ties       = 0;
      in_limit_count = 0;
      seen_levels    = '0;
      gap_seen       = 1'b0;
   endfunction

   // True when an in-threshold score already seen lies closer than the gap to s.
   function automatic bit near_seen(input int s);
      for (int d = 0; d < int'(cfg_gap); d++) begin
         if (s - d >= 0 && seen_levels[s - d]) return 1'b1;
         if (s + d < LEVELS && seen_levels[s + d]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Folds one accepted item into the list state; the last item yields the expected verdict.
   function automatic void predict_score(input logic [bmcr_pkg::SCORE_W-1:0] s,
                                         input logic l);
      verdict_type v;
      bit          beyond;
      if (list_len < CAPACITY) begin
         if (s < low_score) begin
            low_score = s;
            low_pos   = list_len;
            low_ties  = 1;
         end else if (s == low_score) begin
            low_ties++;
         end
         if (s <= cfg_limit) begin
            in_limit_count++;
            if (near_seen(int'(s))) gap_seen = 1'b1;
            seen_levels[s] = 1'b1;
         end
         list_len++;
      end else begin
         list_len = CAPACITY + 1;
      end
      if (!l) return;

      beyond  = low_score > cfg_limit;
      v.index = '0;
      if (list_len > CAPACITY) begin
         v.status = bmcr_pkg::STATUS_OVERFLOW;
      end else if (cfg_mode == bmcr_pkg::MODE_COUNT) begin
         if (in_limit_count > 1) v.status = bmcr_pkg::STATUS_COLLISION;
         else if (!beyond)       v.status = bmcr_pkg::STATUS_FOUND;
         else                    v.status = bmcr_pkg::STATUS_BEYOND;
      end else if (beyond) begin
         v.status = bmcr_pkg::STATUS_BEYOND;
      end else if (cfg_mode == bmcr_pkg::MODE_GAP) begin
         v.status = gap_seen ? bmcr_pkg::STATUS_COLLISION : bmcr_pkg::STATUS_FOUND;
      end else begin
         v.status = (low_ties == 1) ? bmcr_pkg::STATUS_FOUND : bmcr_pkg::STATUS_COLLISION;
      end
      if (v.status == bmcr_pkg::STATUS_FOUND) v.index = low_pos[bmcr_pkg::IDX_W-1:0];
      awaited_verdicts.push_back(v);
      clear_list();
   endfunction

   // Offers one item after a random gap and waits until the block takes it.
   task automatic send_score(input logic [bmcr_pkg::SCORE_W-1:0] s, input logic l);
      int unsigned gap_cycles;
      gap_cycles = $urandom_range(0, send_idle_max);
      if (gap_cycles != 0) begin
         score_ch.valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      score_ch.valid <= 1'b1;
      score_ch.score <= s;
      score_ch.last  <= l;
      @(posedge clock);
      while (!score_ch.ready) @(posedge clock);
      items_accepted++;
      predict_score(s, l);
   endtask

   // Stops offering items and waits until every expected verdict has arrived.
   task automatic wait_drained();
      score_ch.valid <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [bmcr_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [bmcr_pkg::CSR_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Writes all three registers; only called while the block is idle.
   task automatic apply_settings(input logic [bmcr_pkg::MODE_W-1:0] m,
                                 input logic [bmcr_pkg::SCORE_W-1:0] lim,
                                 input logic [bmcr_pkg::SCORE_W-1:0] g);
      write_register(bmcr_pkg::CSR_MODE, bmcr_pkg::CSR_W'(m));
      write_register(bmcr_pkg::CSR_MISMATCH_LIMIT, lim);
      write_register(bmcr_pkg::CSR_MIN_GAP, g);
      csr_wr_en <= 1'b0;
      cfg_mode  = m;
      cfg_limit = lim;
      cfg_gap   = g;
      settings_used++;
   endtask

   // Scores cluster around the threshold, the previous score and its gap window.
   function automatic logic [bmcr_pkg::SCORE_W-1:0] pick_score(
         input logic [bmcr_pkg::SCORE_W-1:0] prev);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom_range(0, 255);
         3, 4:    v = prev;
         5, 6:    v = int'(cfg_limit) + int'($urandom_range(0, 6)) - 3;
         7, 8:    v = int'(prev) + int'($urandom_range(0, 2 * cfg_gap)) - int'(cfg_gap);
         default: v = $urandom_range(0, cfg_limit);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[bmcr_pkg::SCORE_W-1:0];
   endfunction

   // Streams random lists, mostly short, under one setting.
   task automatic stream_random_lists(input logic [bmcr_pkg::MODE_W-1:0] m,
                                      input logic [bmcr_pkg::SCORE_W-1:0] lim,
                                      input logic [bmcr_pkg::SCORE_W-1:0] g,
                                      input int unsigned budget,
                                      input int unsigned idle_max);
      int unsigned                  sent;
      int unsigned                  len;
      logic [bmcr_pkg::SCORE_W-1:0] s;
      sent = 0;
      s    = lim;
      wait_drained();
      apply_settings(m, lim, g);
      send_idle_max = idle_max;
      recv_idle_max = idle_max;
      while (sent < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            s = pick_score(s);
            send_score(s, k == len - 1);
         end
         sent += len;
      end
   endtask

   // Register values after reset: unique minimum, limit one, gap two.
   task automatic test_reset_settings();
      send_idle_max = 3;
      recv_idle_max = 3;
      send_score(8'd0, 1'b1);
      send_score(8'd3, 1'b0);
      send_score(8'd1, 1'b0);
      send_score(8'd1, 1'b1);
      send_score(8'd255, 1'b0);
      send_score(8'd2, 1'b1);
   endtask

   // Each collision rule, the zero gap, the widest gap and the spare mode code.
   task automatic test_rules_directed();
      wait_drained();
      apply_settings(bmcr_pkg::MODE_COUNT, 8'd255, 8'd0);
      send_score(8'd255, 1'b1);
      send_score(8'd0, 1'b0);
      send_score(8'd255, 1'b1);
      wait_drained();
      apply_settings(bmcr_pkg::MODE_COUNT, 8'd0, 8'd1);
      send_score(8'd9, 1'b0);
      send_score(8'd1, 1'b1);
      // With a zero gap even repeated scores never collide.
      wait_drained();
      apply_settings(bmcr_pkg::MODE_GAP, 8'd255, 8'd0);
      send_score(8'd7, 1'b0);
      send_score(8'd7, 1'b1);
      wait_drained();
      apply_settings(bmcr_pkg::MODE_GAP, 8'd255, 8'd255);
      send_score(8'd0, 1'b0);
      send_score(8'd254, 1'b1);
      // A gap exactly equal to min_gap is no collision; scores above the limit are not marked.
      wait_drained();
      apply_settings(bmcr_pkg::MODE_GAP, 8'd100, 8'd3);
      send_score(8'd50, 1'b0);
      send_score(8'd53, 1'b0);
      send_score(8'd200, 1'b1);
      send_score(8'd60, 1'b0);
      send_score(8'd58, 1'b1);
      wait_drained();
      apply_settings(MODE_SPARE, 8'd0, 8'd1);
      send_score(8'd0, 1'b0);
      send_score(8'd0, 1'b1);
      send_score(8'd170, 1'b0);
      send_score(8'd85, 1'b1);
   endtask

   // A full list with its minimum at the last slot, then a list well beyond capacity.
   task automatic test_capacity();
      wait_drained();
      apply_settings(bmcr_pkg::MODE_UNIQUE, 8'd255, 8'd1);
      send_idle_max = 0;
      recv_idle_max = 0;
      for (int k = 0; k < CAPACITY; k++)
         send_score((k == CAPACITY - 1) ? 8'd0 : 8'(1 + $urandom_range(0, 254)),
                    k == CAPACITY - 1);
      for (int k = 0; k < CAPACITY + 6; k++)
         send_score(8'($urandom_range(0, 255)), k == CAPACITY + 5);
      // The list after an overflow must start from cleared state.
      send_score(8'd4, 1'b1);
   endtask

   // Random lists over a spread of settings, extremes included.
   task automatic test_random_settings();
      stream_random_lists(bmcr_pkg::MODE_COUNT, 8'd0, 8'd1, 45, 18);
      stream_random_lists(bmcr_pkg::MODE_COUNT, 8'd30, 8'd255, 45, 18);
      stream_random_lists(bmcr_pkg::MODE_UNIQUE, 8'd255, 8'd1, 45, 18);
      stream_random_lists(bmcr_pkg::MODE_UNIQUE, 8'd5, 8'd200, 45, 18);
      stream_random_lists(bmcr_pkg::MODE_GAP, 8'd40, 8'd3, 45, 18);
      stream_random_lists(bmcr_pkg::MODE_GAP, 8'd255, 8'd255, 45, 0);
      stream_random_lists(bmcr_pkg::MODE_GAP, 8'd100, 8'd1, 45, 18);
      stream_random_lists(MODE_SPARE, 8'd3, 8'd9, 45, 18);
      stream_random_lists(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(1, 255)), 45, 18);
      stream_random_lists(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(1, 255)), 45, 6);
   endtask

   // The receiver holds off for a long stretch while short lists keep arriving.
   task automatic test_back_pressure();
      wait_drained();
      apply_settings(bmcr_pkg::MODE_UNIQUE, 8'd255, 8'd2);
      send_idle_max = 0;
      recv_idle_max = 18;
      hold_asked++;
      for (int k = 0; k < 40; k++)
         send_score(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      send_score(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Result side: random stalls after each verdict, plus the long hold-off on request.
   always @(posedge clock) begin : verdict_receiver
      if (reset) begin
         verdict_ch.ready <= 1'b0;
         recv_wait = 0;
         recv_hold = 0;
      end else begin
         if (hold_asked != hold_granted) begin
            recv_hold    = HOLD_OFF_CYCLES;
            hold_granted = hold_asked;
         end
         if (verdict_ch.valid && verdict_ch.ready) recv_wait = $urandom_range(0, recv_idle_max);
         if (recv_hold != 0) begin
            recv_hold--;
            verdict_ch.ready <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            verdict_ch.ready <= 1'b0;
         end else begin
            verdict_ch.ready <= 1'b1;
         end
      end
   end

   // Each verdict taken is compared with the oldest expectation.
   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && score_ch.valid && !score_ch.ready) input_stall_cycles++;
      if (!reset && verdict_ch.valid && verdict_ch.ready) begin
         if (awaited_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict with no list pending: status %0d index %0d",
                                      verdict_ch.status, verdict_ch.best_index));
         end else begin
            want = awaited_verdicts.pop_front();
            status_tally[want.status]++;
            if (verdict_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         verdict_ch.status, want.status));
            if (verdict_ch.best_index !== want.index)
               report_mismatch($sformatf("best_index %0d, expected %0d",
                                         verdict_ch.best_index, want.index));
         end
      end
   end

   // Main sequence: reset, then each test in turn, then the final verdict.
   initial begin
      score_ch.valid <= 1'b0;
      score_ch.score <= '0;
      score_ch.last  <= 1'b0;
      clear_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_rules_directed();
      test_capacity();
      test_random_settings();
      test_back_pressure();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Covered %0d items under %0d settings, %0d input stall cycles.",
               items_accepted, settings_used, input_stall_cycles);
      $display("Verdicts: %0d found, %0d collision, %0d beyond limit, %0d overflow.",
               status_tally[bmcr_pkg::STATUS_FOUND], status_tally[bmcr_pkg::STATUS_COLLISION],
               status_tally[bmcr_pkg::STATUS_BEYOND], status_tally[bmcr_pkg::STATUS_OVERFLOW]);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
